// ----- hw/rtl/box_overlap_iou_engine_assert.svh -----
// Assertion macros for the box overlap IoU engine.
`ifndef BOX_OVERLAP_IOU_ENGINE_ASSERT_SVH
`define BOX_OVERLAP_IOU_ENGINE_ASSERT_SVH
// implication checked every clock outside reset
`define BOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BOI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hw/rtl/boi_pkg.sv -----
// Package: types and constants of the box overlap IoU engine.
`timescale 1ns / 1ps
package boi_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int COORD_BITS  = 12;
	localparam int RATIO_BITS  = 16;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	localparam int AREA_BITS   = 2 * (COORD_BITS + 1);
	localparam int QUOT_BITS   = RATIO_BITS + 1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_PAIR = 2'd1,
		CMD_SCAN = 2'd2,
		CMD_BEST = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  table_index;
		logic [11:0] query_left;
		logic [11:0] query_top;
		logic [11:0] query_right;
		logic [11:0] query_bottom;
		logic [11:0] other_left;
		logic [11:0] other_top;
		logic [11:0] other_right;
		logic [11:0] other_bottom;
	} req_t;

	typedef struct packed {
		logic [15:0] overlap_ratio;
		logic [4:0]  entry_number;
		logic [5:0]  best_entry;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] bottom;
	} box_t;

	// one job handed from front to back
	typedef struct packed {
		cmd_t                command;
		logic [IDX_BITS-1:0] index;
		box_t                query;
		box_t                other;
		logic [CNT_BITS-1:0] count;
	} job_t;
endpackage

// ----- hw/rtl/boi_front.sv -----
// Front end: takes requests and queues them for the back end.
`timescale 1ns / 1ps
module boi_front import boi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       request,
	output logic       busy,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	output logic       job_valid,
	output job_t       job,
	input  logic       job_pop
);
	logic [5:0] entries_q;
	// two-entry queue
	job_t       fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       accept, push;
	job_t       nj;
	logic [CNT_BITS-1:0] n_eff;

	assign busy   = (cnt_q == 2'd2);
	assign accept = start && !busy;
	assign n_eff  = (entries_q > 6'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH)
		: CNT_BITS'(entries_q);
	// loads go through the queue too so they stay in order with IoU jobs
	assign push   = accept && ((cmd_t'(request.command) != CMD_LOAD)
		|| (32'(request.table_index) < TABLE_DEPTH));

	always_comb begin
		nj.command = cmd_t'(request.command);
		nj.index   = IDX_BITS'(request.table_index);
		nj.query   = '{request.query_left, request.query_top,
			request.query_right, request.query_bottom};
		nj.other   = '{request.other_left, request.other_top,
			request.other_right, request.other_bottom};
		nj.count   = n_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (job_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

	assign job_valid = (cnt_q != 2'd0);
	assign job       = fifo_q[rp_q];
endmodule

// ----- hw/rtl/boi_divider.sv -----
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module boi_divider import boi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [AREA_BITS-1:0] numer,
	input  logic [AREA_BITS-1:0] denom,
	output logic                 done,
	output logic [QUOT_BITS-1:0] quot
);
	localparam int STEP_BITS = $clog2(QUOT_BITS + 1);
	logic [AREA_BITS:0]     rem_q;
	logic [AREA_BITS-1:0]   den_q;
	logic [QUOT_BITS-1:0]   quot_q;
	logic [STEP_BITS-1:0]   step_q;
	logic                   run_q;
	logic [AREA_BITS+1:0]   trial;

	// numer <= denom, so the remainder stays below 2*denom
	assign trial = {1'b0, rem_q} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= STEP_BITS'(QUOT_BITS);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_BITS'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			// first step has bit weight 2^RATIO_BITS
			rem_q  <= {1'b0, numer};
			den_q  <= denom;
			quot_q <= '0;
		end else if (run_q) begin
			if (!trial[AREA_BITS+1]) begin
				rem_q  <= {trial[AREA_BITS-1:0], 1'b0};
				quot_q <= {quot_q[QUOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[AREA_BITS-1:0], 1'b0};
				quot_q <= {quot_q[QUOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
endmodule

// ----- hw/rtl/boi_back.sv -----
// Back end: stores loaded boxes, walks the reference table, computes IoU, emits results.
`timescale 1ns / 1ps
`include "box_overlap_iou_engine_assert.svh"
module boi_back import boi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  job_t                job,
	output logic                job_pop,
	output logic                done,
	output res_t                result
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_GEOM  = 6'b000100,
		ST_AREA  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	localparam int SPAN = COORD_BITS + 1;

	box_t mem [TABLE_DEPTH];
	box_t rd_q;
	state_t state_q;
	job_t   job_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [QUOT_BITS-1:0] best_r_q;
	logic [CNT_BITS-1:0]  best_i_q;
	box_t a, b;
	logic zero_s2;
	logic [SPAN-1:0] cols_s2, rows_s2, wa_s2, ha_s2, wb_s2, hb_s2;
	logic [AREA_BITS-1:0] inter_s3, uni_s3;
	logic zero_s3;
	logic [AREA_BITS+1:0] usum;
	logic div_go, div_done;
	logic go_q;
	logic [QUOT_BITS-1:0] quot;
	logic [RATIO_BITS-1:0] ratio;
	logic [QUOT_BITS-1:0] q_eff;
	logic is_last;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid && job.command == CMD_LOAD)
			mem[job.index] <= job.query;
		rd_q <= mem[idx_q[IDX_BITS-1:0]];
	end

	assign a = job_q.query;
	assign b = (job_q.command == CMD_PAIR) ? job_q.other : rd_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_GEOM) begin
			zero_s2 <= (a.right < a.left) || (a.bottom < a.top)
				|| (b.right < b.left) || (b.bottom < b.top)
				|| (a.left > b.right) || (a.top > b.bottom)
				|| (a.right < b.left) || (a.bottom < b.top);
			cols_s2 <= SPAN'(((a.right < b.right) ? a.right : b.right)
				- ((a.left > b.left) ? a.left : b.left)) + 1'b1;
			rows_s2 <= SPAN'(((a.bottom < b.bottom) ? a.bottom : b.bottom)
				- ((a.top > b.top) ? a.top : b.top)) + 1'b1;
			wa_s2 <= SPAN'(a.right - a.left) + 1'b1;
			ha_s2 <= SPAN'(a.bottom - a.top) + 1'b1;
			wb_s2 <= SPAN'(b.right - b.left) + 1'b1;
			hb_s2 <= SPAN'(b.bottom - b.top) + 1'b1;
		end
	end

	assign usum = AREA_BITS'(wa_s2 * ha_s2) + AREA_BITS'(wb_s2 * hb_s2)
		- AREA_BITS'(cols_s2 * rows_s2);

	always_ff @(posedge clk) begin
		if (state_q == ST_AREA) begin
			inter_s3 <= zero_s2 ? '0 : AREA_BITS'(cols_s2 * rows_s2);
			uni_s3   <= AREA_BITS'(usum);
			zero_s3  <= zero_s2 || (usum == '0);
		end
	end

	assign div_go = (state_q == ST_AREA);

	// start the divider once the area registers hold this entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_q <= 1'b0;
		else go_q <= div_go;
	end

	boi_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(go_q),
		.numer(inter_s3), .denom(uni_s3), .done(div_done), .quot(quot)
	);

	assign q_eff = zero_s3 ? '0 : quot;
	assign ratio = q_eff[QUOT_BITS-1] ? '1 : q_eff[RATIO_BITS-1:0];
	assign is_last = (idx_q + 1'b1 == job_q.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			done     <= 1'b0;
			best_r_q <= '0;
			best_i_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						idx_q    <= '0;
						best_r_q <= '0;
						best_i_q <= '0;
						if (job.command == CMD_PAIR
							|| (job.command != CMD_LOAD && job.count != '0)) begin
							state_q <= ST_READ;
						end else if (job.command == CMD_BEST) begin
							done    <= 1'b1;
						end
					end
				end
				ST_READ: state_q <= ST_GEOM;
				ST_GEOM: state_q <= ST_AREA;
				ST_AREA: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (job_q.command == CMD_PAIR) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (job_q.command == CMD_SCAN) done <= 1'b1;
						if (QUOT_BITS'(ratio) > best_r_q) begin
							best_r_q <= QUOT_BITS'(ratio);
							best_i_q <= idx_q + 1'b1;
						end
						if (is_last) begin
							if (job_q.command == CMD_BEST) done <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) job_q <= job;
		if (state_q == ST_IDLE) begin
			result <= '{16'd0, 5'd0, 6'd0, 1'b1};
		end else if (state_q == ST_EMIT) begin
			if (job_q.command == CMD_BEST) begin
				if (QUOT_BITS'(ratio) > best_r_q) begin
					result <= '{16'(ratio), 5'd0, 6'(idx_q + 1'b1), 1'b1};
				end else begin
					result <= '{16'(best_r_q), 5'd0, 6'(best_i_q), 1'b1};
				end
			end else if (job_q.command == CMD_SCAN) begin
				result <= '{16'(ratio), 5'(idx_q), 6'd0, is_last};
			end else begin
				result <= '{16'(ratio), 5'd0, 6'd0, 1'b1};
			end
		end
	end

	assign job_pop = (state_q == ST_IDLE) && job_valid;

	`BOI_ASSERT_NEXT(a_div_wait, clk, arst_n, state_q == ST_AREA, state_q == ST_DIV)
	`BOI_ASSERT_IMP(a_pop_idle, clk, arst_n, job_pop, state_q == ST_IDLE)
	`BOI_ASSERT_IMP(a_idx_range, clk, arst_n, state_q == ST_EMIT && job_q.command != CMD_PAIR,
		idx_q < job_q.count)
	`BOI_ASSERT_NEXT(a_load_quiet, clk, arst_n, job_pop && job.command == CMD_LOAD, !done)
endmodule

// ----- hw/rtl/box_overlap_iou_engine.sv -----
// Top level of the box overlap IoU engine.
`timescale 1ns / 1ps
// Box overlap IoU engine.
// Requests: start with request (packed struct) is taken when busy is low.
// Commands: load a reference box, IoU of a box pair, scan the query box
// against entries 0..entries_in_use-1, or best match over those entries.
// Config: cfg_we writes cfg_wdata into entries_in_use (values above the
// table depth count as the depth).
// Results: done pulses for one cycle with result; it cannot be stalled.
// Front end queues up to two requests, loads included, so table writes
// keep request order; busy is high while both slots are taken.
// The back end takes a queued request when it is idle. Each IoU then
// steps through table read, geometry, area multiplies, the restoring
// divider (load, 17 quotient bits, done) and the result state.
// Pair: one result; the back end starts the next request once it is out.
// Scan: one result per entry in use, in entry order; best match gives
// its one result after the last entry in use.
// A load writes the table from the idle back end and gives no result.
// Reset clears the queue, the sequencer and entries_in_use; table contents
// are undefined until loaded.
module box_overlap_iou_engine import boi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       request,
	output logic       busy,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	output logic       done,
	output res_t       result
);
	logic job_valid, job_pop;
	job_t job;

	boi_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .job_valid(job_valid),
		.job(job), .job_pop(job_pop)
	);

	boi_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job), .job_pop(job_pop),
		.done(done), .result(result)
	);
endmodule
